>>> rtl/core/trqs_pkg.sv
package trqs_pkg;

	// request codes
	localparam logic [2:0] REQ_SPAWN     = 3'd0;
	localparam logic [2:0] REQ_WAKE      = 3'd1;
	localparam logic [2:0] REQ_ABORT     = 3'd2;
	localparam logic [2:0] REQ_DISPATCH  = 3'd3;
	localparam logic [2:0] REQ_POLL_DONE = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// dispatch kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_POLL   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	localparam logic [15:0] POLLS_MAX = 16'hFFFF;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_POP  = 6'b000100,
		ST_SKIP = 6'b001000,
		ST_PRD  = 6'b010000,
		ST_PUPD = 6'b100000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic pop;
		logic poll_upd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_disp;
		logic ring_empty;
		logic head_done;
	} stat_t;

endpackage

>>> rtl/core/trqs_ctrl.sv
module trqs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  trqs_pkg::stat_t  stat,
	output trqs_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done
);

	trqs_pkg::state_t state_q;
	trqs_pkg::state_t state_nx;
	logic             done_q;
	logic             fin;

	// next state and finish detection
	always_comb begin
		state_nx = state_q;
		fin      = 1'b0;
		case (state_q)
			trqs_pkg::ST_IDLE: begin
				if (start) state_nx = trqs_pkg::ST_EXEC;
			end
			trqs_pkg::ST_EXEC: begin
				if (stat.is_disp) begin
					state_nx = trqs_pkg::ST_POP;
				end else begin
					state_nx = trqs_pkg::ST_IDLE;
					fin      = 1'b1;
				end
			end
			trqs_pkg::ST_POP: begin
				if (stat.ring_empty) begin
					state_nx = trqs_pkg::ST_IDLE;
					fin      = 1'b1;
				end else if (stat.head_done) begin
					state_nx = trqs_pkg::ST_SKIP;
				end else begin
					state_nx = trqs_pkg::ST_PRD;
				end
			end
			trqs_pkg::ST_SKIP: state_nx = trqs_pkg::ST_POP;
			trqs_pkg::ST_PRD:  state_nx = trqs_pkg::ST_PUPD;
			trqs_pkg::ST_PUPD: begin
				state_nx = trqs_pkg::ST_IDLE;
				fin      = 1'b1;
			end
			default: begin
				state_nx = trqs_pkg::ST_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trqs_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= fin;
		end
	end

	// commands
	assign cmd.load     = (state_q == trqs_pkg::ST_IDLE) && start;
	assign cmd.exec     = (state_q == trqs_pkg::ST_EXEC);
	assign cmd.pop      = (state_q == trqs_pkg::ST_POP);
	assign cmd.poll_upd = (state_q == trqs_pkg::ST_PUPD);

	assign busy = (state_q != trqs_pkg::ST_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == trqs_pkg::ST_IDLE))
		else $error("result strobe while busy");

	a_empty_finish: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == trqs_pkg::ST_POP) && stat.ring_empty) |=> done_q)
		else $error("empty dispatch gave no result");

	a_exec_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == trqs_pkg::ST_EXEC) |-> ($past(state_q) == trqs_pkg::ST_IDLE))
		else $error("request executed without acceptance");
`endif

endmodule

>>> rtl/core/trqs_dp.sv
module trqs_dp #(
	parameter int TASK_SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  trqs_pkg::cmd_t   cmd,
	output trqs_pkg::stat_t  stat,
	input  logic [2:0]       req_type,
	input  logic [3:0]       task_id,
	input  logic             poll_ready,
	output logic [1:0]       status,
	output logic [1:0]       dispatch_kind,
	output logic [3:0]       dispatched_task,
	output logic [15:0]      task_polls,
	output logic [4:0]       ready_count,
	output logic [4:0]       active_count,
	output logic             overflowed
);

	localparam int IW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam int XW = (IW > 4) ? IW : 4;
	localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);
	localparam logic [IW-1:0] LAST_C  = IW'(TASK_SLOTS - 1);

	// captured request
	logic [2:0] req_q;
	logic [3:0] id_q;
	logic       pready_q;

	// ring and per-slot state
	logic [IW-1:0]         ring_mem [TASK_SLOTS];
	logic [IW-1:0]         rd_q;
	logic [IW-1:0]         head_q;
	logic [CW-1:0]         len_q;
	logic [CW-1:0]         live_q;
	logic                  ovf_q;
	logic [TASK_SLOTS-1:0] queued_q;
	logic [TASK_SLOTS-1:0] sdone_q;
	logic [TASK_SLOTS-1:0] cancel_q;
	logic [15:0]           polls_mem [TASK_SLOTS];
	logic [15:0]           polls_rd_q;
	logic [IW-1:0]         chosen_q;
	logic [1:0]            kind_q;

	// result registers
	logic [1:0]    res_status_q;
	logic [1:0]    res_kind_q;
	logic [IW-1:0] res_task_q;
	logic [15:0]   res_polls_q;

	logic [XW-1:0] id_x;
	logic          slot_ok;
	logic [IW-1:0] slot;
	logic          sd;
	logic          sq;
	logic          ring_full;
	logic [CW:0]   wsum;
	logic [CW:0]   wsum_wrap;
	logic [IW-1:0] waddr;
	logic          do_exec;
	logic [1:0]    ex_status;
	logic          ex_spawn;
	logic          ex_push;
	logic          ex_ovf;
	logic          ex_abort;
	logic          ex_retire;
	logic          pop_take;
	logic          pop_hit;
	logic          pop_cancel;
	logic [15:0]   polls_inc;

	// slot decode and ring write address
	assign id_x      = XW'(id_q);
	assign slot_ok   = {1'b0, id_x} < (XW+1)'(TASK_SLOTS);
	assign slot      = id_x[IW-1:0];
	assign sd        = sdone_q[slot];
	assign sq        = queued_q[slot];
	assign ring_full = (len_q >= SLOTS_C);
	assign wsum      = (CW+1)'(head_q) + (CW+1)'(len_q);
	assign wsum_wrap = (wsum >= (CW+1)'(TASK_SLOTS)) ? (wsum - (CW+1)'(TASK_SLOTS)) : wsum;
	assign waddr     = wsum_wrap[IW-1:0];
	assign do_exec   = cmd.exec && (req_q != trqs_pkg::REQ_DISPATCH);

	// non-dispatch request decision
	always_comb begin
		ex_status = trqs_pkg::STATUS_OK;
		ex_spawn  = 1'b0;
		ex_push   = 1'b0;
		ex_ovf    = 1'b0;
		ex_abort  = 1'b0;
		ex_retire = 1'b0;
		if (req_q > trqs_pkg::REQ_POLL_DONE || !slot_ok) begin
			ex_status = trqs_pkg::STATUS_FAIL;
		end else begin
			case (req_q)
				trqs_pkg::REQ_SPAWN: begin
					if (!sd || live_q >= SLOTS_C) begin
						ex_status = trqs_pkg::STATUS_FAIL;
					end else if (!sq && ring_full) begin
						ex_ovf    = 1'b1;
						ex_status = trqs_pkg::STATUS_FAIL;
					end else begin
						ex_spawn = 1'b1;
						ex_push  = !sq;
					end
				end
				trqs_pkg::REQ_WAKE: begin
					if (!sd && !sq) begin
						if (ring_full) begin
							ex_ovf    = 1'b1;
							ex_status = trqs_pkg::STATUS_FAIL;
						end else begin
							ex_push = 1'b1;
						end
					end
				end
				trqs_pkg::REQ_ABORT: begin
					if (!sd) begin
						ex_abort = 1'b1;
						if (!sq) begin
							if (ring_full) begin
								ex_ovf    = 1'b1;
								ex_status = trqs_pkg::STATUS_FAIL;
							end else begin
								ex_push = 1'b1;
							end
						end
					end
				end
				trqs_pkg::REQ_POLL_DONE: begin
					if (sd) ex_status = trqs_pkg::STATUS_FAIL;
					else if (pready_q) ex_retire = 1'b1;
				end
				default: begin
					ex_status = trqs_pkg::STATUS_FAIL;
				end
			endcase
		end
	end

	// dispatch pop step
	assign pop_take   = cmd.pop && (len_q != '0);
	assign pop_hit    = pop_take && !sdone_q[rd_q];
	assign pop_cancel = pop_hit && cancel_q[rd_q];
	assign polls_inc  = (polls_rd_q == trqs_pkg::POLLS_MAX) ? polls_rd_q : polls_rd_q + 16'd1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			len_q    <= '0;
			live_q   <= '0;
			ovf_q    <= 1'b0;
			queued_q <= '0;
			sdone_q  <= '1;
			cancel_q <= '0;
		end else begin
			if (do_exec) begin
				if (ex_ovf) ovf_q <= 1'b1;
				if (ex_spawn) begin
					sdone_q[slot]  <= 1'b0;
					cancel_q[slot] <= 1'b0;
					live_q         <= live_q + CW'(1);
				end
				if (ex_abort) cancel_q[slot] <= 1'b1;
				if (ex_push) begin
					len_q          <= len_q + CW'(1);
					queued_q[slot] <= 1'b1;
				end
				if (ex_retire) begin
					sdone_q[slot] <= 1'b1;
					if (live_q != '0) live_q <= live_q - CW'(1);
				end
			end
			if (pop_take) begin
				head_q         <= (head_q == LAST_C) ? '0 : head_q + IW'(1);
				len_q          <= len_q - CW'(1);
				queued_q[rd_q] <= 1'b0;
				if (pop_cancel) begin
					sdone_q[rd_q] <= 1'b1;
					if (live_q != '0) live_q <= live_q - CW'(1);
				end
			end
		end
	end

	// request capture, memories and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			id_q     <= task_id;
			pready_q <= poll_ready;
		end
		rd_q <= ring_mem[head_q];
		if (do_exec && ex_push) ring_mem[waddr] <= slot;
		polls_rd_q <= polls_mem[chosen_q];
		if (do_exec && ex_spawn) begin
			polls_mem[slot] <= '0;
		end else if (cmd.poll_upd && kind_q == trqs_pkg::KIND_POLL) begin
			polls_mem[chosen_q] <= polls_inc;
		end
		if (pop_hit) begin
			chosen_q <= rd_q;
			kind_q   <= cancel_q[rd_q] ? trqs_pkg::KIND_CANCEL : trqs_pkg::KIND_POLL;
		end
		if (do_exec) begin
			res_status_q <= ex_status;
			res_kind_q   <= trqs_pkg::KIND_NONE;
			res_task_q   <= '0;
			res_polls_q  <= '0;
		end else if (cmd.pop && len_q == '0) begin
			res_status_q <= trqs_pkg::STATUS_EMPTY;
			res_kind_q   <= trqs_pkg::KIND_NONE;
			res_task_q   <= '0;
			res_polls_q  <= '0;
		end else if (cmd.poll_upd) begin
			res_status_q <= trqs_pkg::STATUS_OK;
			res_kind_q   <= kind_q;
			res_task_q   <= chosen_q;
			res_polls_q  <= (kind_q == trqs_pkg::KIND_POLL) ? polls_inc : polls_rd_q;
		end
	end

	// status to controller
	assign stat.is_disp    = (req_q == trqs_pkg::REQ_DISPATCH);
	assign stat.ring_empty = (len_q == '0);
	assign stat.head_done  = sdone_q[rd_q];

	assign status          = res_status_q;
	assign dispatch_kind   = res_kind_q;
	assign dispatched_task = 4'(res_task_q);
	assign task_polls      = res_polls_q;
	assign ready_count     = 5'(len_q);
	assign active_count    = 5'(live_q);
	assign overflowed      = ovf_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= SLOTS_C)
		else $error("ring length beyond capacity");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= SLOTS_C)
		else $error("live count beyond capacity");

	a_queued_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queued_q) == int'(len_q))
		else $error("queued flags disagree with ring length");
`endif

endmodule

>>> rtl/core/task_ready_queue_scheduler.sv
// Wake, spawn, abort and poll done pass through EXEC, which writes their result registers.
// Dispatch runs EXEC and POP, then SKIP and POP per completed entry skipped, then PRD and
// PUPD; an empty ring ends it at POP. Each skip is one ring read plus one pop step.
// A request is accepted only while idle, dispatch included; the next request can be
// accepted in the cycle its predecessor's result is shown. The receiver cannot stall.
// Reset: arst_n clears the ring pointers, counts, overflow and slot flags at once.
module task_ready_queue_scheduler #(
	parameter int TASK_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [3:0]  task_id,
	input  logic        poll_ready,
	output logic        done,
	output logic [1:0]  status,
	output logic [1:0]  dispatch_kind,
	output logic [3:0]  dispatched_task,
	output logic [15:0] task_polls,
	output logic [4:0]  ready_count,
	output logic [4:0]  active_count,
	output logic        overflowed
);

	trqs_pkg::cmd_t  cmd;
	trqs_pkg::stat_t stat;

	// sequencer
	trqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// ring, slot flags and poll counters
	trqs_dp #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_type        (req_type),
		.task_id         (task_id),
		.poll_ready      (poll_ready),
		.status          (status),
		.dispatch_kind   (dispatch_kind),
		.dispatched_task (dispatched_task),
		.task_polls      (task_polls),
		.ready_count     (ready_count),
		.active_count    (active_count),
		.overflowed      (overflowed)
	);

endmodule

>>> test/testbench.sv
module testbench;

	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 1550;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [15:0] polls;
		logic [4:0]  ring_fill;
		logic [4:0]  live;
		logic        ovf;
	} sched_result_t;

	// shadow scheduler plus the queue of results still owed by the block
	class ready_queue_scoreboard;
		logic [3:0]    ring[SLOTS];
		logic [3:0]    head;
		logic [4:0]    fill;
		logic [4:0]    live;
		logic          ovf;
		logic          queued[SLOTS];
		logic          finished[SLOTS];
		logic          cancel[SLOTS];
		logic [15:0]   polls[SLOTS];
		logic [3:0]    last_polled;
		int            errors;
		sched_result_t owed[$];

		function new();
			head = '0;
			fill = '0;
			live = '0;
			ovf = 1'b0;
			last_polled = '0;
			errors = 0;
			for (int i = 0; i < SLOTS; i++) begin
				ring[i] = '0;
				queued[i] = 1'b0;
				finished[i] = 1'b1;
				cancel[i] = 1'b0;
				polls[i] = '0;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// dedup enqueue; zero on a full ring
		function bit enqueue_slot(logic [3:0] s);
			logic [3:0] tail;
			if (finished[s] || queued[s])
				return 1'b1;
			if (fill >= SLOTS) begin
				ovf = 1'b1;
				return 1'b0;
			end
			tail = head + fill[3:0];
			ring[tail] = s;
			fill = fill + 1'b1;
			queued[s] = 1'b1;
			return 1'b1;
		endfunction

		function logic [3:0] dequeue_slot();
			logic [3:0] s;
			s = ring[head];
			head = head + 1'b1;
			fill = fill - 1'b1;
			queued[s] = 1'b0;
			return s;
		endfunction

		function void retire(logic [3:0] s);
			finished[s] = 1'b1;
			if (live > 0)
				live = live - 1'b1;
		endfunction

		// next scheduler state and the result of one request
		function sched_result_t step_scheduler(logic [2:0] req, logic [3:0] id, logic rdy);
			sched_result_t r;
			logic [3:0] s;
			r.status = trqs_pkg::STATUS_OK;
			r.kind = trqs_pkg::KIND_NONE;
			r.slot = '0;
			r.polls = '0;
			case (req)
				trqs_pkg::REQ_SPAWN: begin
					if (!finished[id] || live >= SLOTS) begin
						r.status = trqs_pkg::STATUS_FAIL;
					end else if (!queued[id] && fill >= SLOTS) begin
						ovf = 1'b1;
						r.status = trqs_pkg::STATUS_FAIL;
					end else begin
						finished[id] = 1'b0;
						cancel[id] = 1'b0;
						polls[id] = '0;
						live = live + 1'b1;
						void'(enqueue_slot(id));
					end
				end
				trqs_pkg::REQ_WAKE: begin
					if (!enqueue_slot(id))
						r.status = trqs_pkg::STATUS_FAIL;
				end
				trqs_pkg::REQ_ABORT: begin
					if (!finished[id]) begin
						cancel[id] = 1'b1;
						if (!enqueue_slot(id))
							r.status = trqs_pkg::STATUS_FAIL;
					end
				end
				trqs_pkg::REQ_DISPATCH: begin
					r.status = trqs_pkg::STATUS_EMPTY;
					while (fill > 0) begin
						s = dequeue_slot();
						if (!finished[s]) begin
							r.status = trqs_pkg::STATUS_OK;
							r.slot = s;
							if (cancel[s]) begin
								retire(s);
								r.kind = trqs_pkg::KIND_CANCEL;
							end else begin
								if (polls[s] < trqs_pkg::POLLS_MAX)
									polls[s] = polls[s] + 1'b1;
								r.kind = trqs_pkg::KIND_POLL;
								last_polled = s;
							end
							r.polls = polls[s];
							break;
						end
					end
				end
				trqs_pkg::REQ_POLL_DONE: begin
					if (finished[id])
						r.status = trqs_pkg::STATUS_FAIL;
					else if (rdy)
						retire(id);
				end
				default: r.status = trqs_pkg::STATUS_FAIL;
			endcase
			r.ring_fill = fill;
			r.live = live;
			r.ovf = ovf;
			return r;
		endfunction

		function void note_request(logic [2:0] req, logic [3:0] id, logic rdy);
			owed.push_back(step_scheduler(req, id, rdy));
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s expected %0d got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t want;
			if (owed.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = owed.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("dispatch_kind", want.kind, got.kind);
			compare_field("dispatched_task", want.slot, got.slot);
			compare_field("task_polls", want.polls, got.polls);
			compare_field("ready_count", want.ring_fill, got.ring_fill);
			compare_field("active_count", want.live, got.live);
			compare_field("overflowed", want.ovf, got.ovf);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [3:0]  task_id;
	logic        poll_ready;
	logic        done;
	logic [1:0]  status;
	logic [1:0]  dispatch_kind;
	logic [3:0]  dispatched_task;
	logic [15:0] task_polls;
	logic [4:0]  ready_count;
	logic [4:0]  active_count;
	logic        overflowed;

	ready_queue_scoreboard sb = new();
	int stall_cycles;

	task_ready_queue_scheduler #(.TASK_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.task_id(task_id),
		.poll_ready(poll_ready),
		.done(done),
		.status(status),
		.dispatch_kind(dispatch_kind),
		.dispatched_task(dispatched_task),
		.task_polls(task_polls),
		.ready_count(ready_count),
		.active_count(active_count),
		.overflowed(overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// present one request and hold it until the block takes it
	task automatic send_request(logic [2:0] req, logic [3:0] id, logic rdy);
		@(negedge clk);
		start <= 1'b1;
		req_type <= req;
		task_id <= id;
		poll_ready <= rdy;
		do @(posedge clk); while (busy);
		sb.note_request(req, id, rdy);
	endtask

	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
		req_type <= 3'($urandom_range(7));
		task_id <= 4'($urandom_range(15));
		poll_ready <= 1'($urandom_range(1));
	endtask

	// weighted random request, poll done mostly aimed at the task last handed out
	task automatic send_random();
		int pick;
		logic [2:0] req;
		logic [3:0] id;
		pick = $urandom_range(99);
		id = 4'($urandom_range(15));
		if (pick < 20)
			req = trqs_pkg::REQ_SPAWN;
		else if (pick < 38)
			req = trqs_pkg::REQ_WAKE;
		else if (pick < 48)
			req = trqs_pkg::REQ_ABORT;
		else if (pick < 73)
			req = trqs_pkg::REQ_DISPATCH;
		else if (pick < 95) begin
			req = trqs_pkg::REQ_POLL_DONE;
			if ($urandom_range(99) < 70)
				id = sb.last_polled;
		end else
			req = 3'($urandom_range(5, 7));
		send_request(req, id, 1'($urandom_range(1)));
	endtask

	// result monitor
	always @(posedge clk) begin
		sched_result_t got;
		if (arst_n && done) begin
			got.status = status;
			got.kind = dispatch_kind;
			got.slot = dispatched_task;
			got.polls = task_polls;
			got.ring_fill = ready_count;
			got.live = active_count;
			got.ovf = overflowed;
			sb.check_result(got);
		end
	end

	// watchdog on cycles with no request and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		task_id = '0;
		poll_ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fill every slot and the ring, then the corner requests
		for (int i = 0; i < SLOTS; i++)
			send_request(trqs_pkg::REQ_SPAWN, 4'(i), 1'b0);
		send_request(trqs_pkg::REQ_SPAWN, 4'd3, 1'b0);
		send_request(trqs_pkg::REQ_WAKE, 4'd4, 1'b1);
		send_request(trqs_pkg::REQ_ABORT, 4'd1, 1'b0);
		send_request(trqs_pkg::REQ_DISPATCH, 4'd15, 1'b1);
		send_request(trqs_pkg::REQ_DISPATCH, 4'd0, 1'b0);
		send_request(trqs_pkg::REQ_POLL_DONE, 4'd0, 1'b0);
		send_request(trqs_pkg::REQ_POLL_DONE, 4'd0, 1'b1);
		send_request(trqs_pkg::REQ_POLL_DONE, 4'd0, 1'b1);
		send_request(trqs_pkg::REQ_WAKE, 4'd0, 1'b0);
		send_request(trqs_pkg::REQ_ABORT, 4'd0, 1'b1);
		send_request(3'd7, 4'd15, 1'b1);

		// random: idle stretch-free window in the middle, one full drain later on
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n < 500 || n >= 800)
				while ($urandom_range(99) < 33)
					idle_cycle();
			if (n == 1000) begin
				idle_cycle();
				while (sb.pending() != 0)
					@(posedge clk);
			end
			send_random();
		end
		idle_cycle();

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
